@@ rtl/frci_pkg.sv @@
package frci_pkg;

   typedef enum logic [1:0] {
      ST_OK       = 2'd0,
      ST_BAD_SIZE = 2'd1,
      ST_OVERLAP  = 2'd2,
      ST_FULL     = 2'd3
   } status_type;

   localparam int unsigned LEN_BITS = 34;
   localparam logic [31:0] MIN_BLOCK = 32'd8;
   localparam logic [31:0] ALIGN_MASK = 32'd3;

endpackage

@@ rtl/free_range_coalescing_insert_unit.sv @@
// Returns freed blocks to an address-ordered table of free ranges, merging
// with neighbors and keeping a running total of free bytes. An item is taken
// when start is high and busy is low, and exactly one result appears later
// on the rsp_ ports with rsp_valid high for a single cycle; the receiver
// cannot stall, so it must take every result when it is shown. A bad size
// is answered in the next cycle, with busy kept low. Any other item walks the
// table through a single read port, entry by entry, and an insert or a
// two-sided merge then moves the later entries one place. busy stays high
// until the result is issued, and a new item may be taken in the cycle that
// shows the result.
module free_range_coalescing_insert_unit #(
   parameter int unsigned MAX_RANGES   = 64,
   parameter int unsigned ADDRESS_BITS = 32
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   output logic        busy,
   input  logic [31:0] req_block_address,
   input  logic signed [31:0] req_block_size,
   output logic        rsp_valid,
   output logic [1:0]  rsp_status,
   output logic [31:0] rsp_total_free_bytes,
   output logic [6:0]  rsp_ranges_in_use
);

   localparam int unsigned IDX_BITS = $clog2(MAX_RANGES);
   localparam int unsigned CNT_BITS = $clog2(MAX_RANGES + 1);
   localparam int unsigned LB = frci_pkg::LEN_BITS;
   localparam int unsigned WORD = ADDRESS_BITS + LB;
   localparam logic [CNT_BITS-1:0] MAX_CNT = CNT_BITS'(MAX_RANGES);

   typedef enum logic [3:0] {
      S_IDLE, S_SCAN_RD, S_SCAN_CHK, S_NEXT_CHK,
      S_SHUP_RD, S_SHUP_WR, S_INS_WR, S_DROP_RD, S_DROP_WR
   } state_type;

   state_type state_ff, state_in;
   logic [CNT_BITS-1:0] cnt_ff, cnt_in, i_ff, i_in, j_ff, j_in;
   logic [31:0] total_ff, total_in, size_ff, size_in;
   logic [ADDRESS_BITS-1:0] addr_ff, addr_in, cur_start_ff, cur_start_in;
   logic [LB-1:0] cur_len_ff, cur_len_in;
   logic rsp_valid_ff, rsp_valid_in;
   frci_pkg::status_type status_ff, status_in;
   logic [31:0] rsp_total_ff, rsp_total_in;
   logic [CNT_BITS-1:0] rsp_cnt_ff, rsp_cnt_in;

   logic we;
   logic [IDX_BITS-1:0] waddr, raddr;
   logic [WORD-1:0] wdata, rdata;
   logic [ADDRESS_BITS-1:0] rd_start;
   logic [LB-1:0] rd_len, rd_end, bend, size_w;
   logic [31:0] raw_size, clamp_size;

   frci_ram #(.WIDTH(WORD), .DEPTH(MAX_RANGES)) u_table (
      .clock(clock), .we(we), .waddr(waddr), .wdata(wdata),
      .raddr(raddr), .rdata(rdata)
   );

   assign rd_start = rdata[WORD-1:LB];
   assign rd_len = rdata[LB-1:0];
   assign rd_end = LB'(rd_start) + rd_len;
   assign size_w = LB'(size_ff);
   assign bend = LB'(addr_ff) + size_w;
   assign raw_size = req_block_size;
   assign clamp_size = (raw_size < frci_pkg::MIN_BLOCK) ? frci_pkg::MIN_BLOCK : raw_size;

   always_comb begin
      state_in = state_ff;
      cnt_in = cnt_ff;
      i_in = i_ff;
      j_in = j_ff;
      total_in = total_ff;
      size_in = size_ff;
      addr_in = addr_ff;
      cur_start_in = cur_start_ff;
      cur_len_in = cur_len_ff;
      rsp_valid_in = 1'b0;
      status_in = frci_pkg::ST_OK;
      we = 1'b0;
      waddr = i_ff[IDX_BITS-1:0];
      wdata = {addr_ff, size_w};
      raddr = i_ff[IDX_BITS-1:0];
      unique case (state_ff)
         S_IDLE: begin
            if (start) begin
               addr_in = req_block_address[ADDRESS_BITS-1:0];
               size_in = (clamp_size + frci_pkg::ALIGN_MASK) & ~frci_pkg::ALIGN_MASK;
               i_in = '0;
               if (req_block_size <= 0) begin
                  rsp_valid_in = 1'b1;
                  status_in = frci_pkg::ST_BAD_SIZE;
               end else begin
                  state_in = S_SCAN_RD;
               end
            end
         end
         S_SCAN_RD: begin
            if (i_ff == cnt_ff) begin
               rsp_valid_in = 1'b1;
               state_in = S_IDLE;
               if (cnt_ff == MAX_CNT) begin
                  status_in = frci_pkg::ST_FULL;
               end else begin
                  we = 1'b1;
                  cnt_in = cnt_ff + 1'b1;
                  total_in = total_ff + size_ff;
               end
            end else begin
               state_in = S_SCAN_CHK;
            end
         end
         S_SCAN_CHK: begin
            cur_start_in = rd_start;
            cur_len_in = rd_len;
            raddr = IDX_BITS'(i_ff + 1'b1);
            if (LB'(rd_start) > bend) begin
               if (cnt_ff == MAX_CNT) begin
                  rsp_valid_in = 1'b1;
                  status_in = frci_pkg::ST_FULL;
                  state_in = S_IDLE;
               end else begin
                  j_in = cnt_ff - 1'b1;
                  state_in = S_SHUP_RD;
               end
            end else if (LB'(rd_start) == bend) begin
               we = 1'b1;
               wdata = {addr_ff, rd_len + size_w};
               total_in = total_ff + size_ff;
               rsp_valid_in = 1'b1;
               state_in = S_IDLE;
            end else if (LB'(addr_ff) < rd_end) begin
               rsp_valid_in = 1'b1;
               status_in = frci_pkg::ST_OVERLAP;
               state_in = S_IDLE;
            end else if (LB'(addr_ff) == rd_end) begin
               if (i_ff + 1'b1 < cnt_ff) begin
                  state_in = S_NEXT_CHK;
               end else begin
                  we = 1'b1;
                  wdata = {rd_start, rd_len + size_w};
                  total_in = total_ff + size_ff;
                  rsp_valid_in = 1'b1;
                  state_in = S_IDLE;
               end
            end else begin
               i_in = i_ff + 1'b1;
               state_in = S_SCAN_RD;
            end
         end
         S_NEXT_CHK: begin
            if (LB'(rd_start) < bend) begin
               rsp_valid_in = 1'b1;
               status_in = frci_pkg::ST_OVERLAP;
               state_in = S_IDLE;
            end else if (LB'(rd_start) == bend) begin
               we = 1'b1;
               wdata = {cur_start_ff, cur_len_ff + size_w + rd_len};
               total_in = total_ff + size_ff;
               j_in = i_ff + 2'd2;
               state_in = S_DROP_RD;
            end else begin
               we = 1'b1;
               wdata = {cur_start_ff, cur_len_ff + size_w};
               total_in = total_ff + size_ff;
               rsp_valid_in = 1'b1;
               state_in = S_IDLE;
            end
         end
         S_SHUP_RD: begin
            raddr = j_ff[IDX_BITS-1:0];
            state_in = S_SHUP_WR;
         end
         S_SHUP_WR: begin
            we = 1'b1;
            waddr = IDX_BITS'(j_ff + 1'b1);
            wdata = rdata;
            if (j_ff == i_ff) begin
               state_in = S_INS_WR;
            end else begin
               j_in = j_ff - 1'b1;
               state_in = S_SHUP_RD;
            end
         end
         S_INS_WR: begin
            we = 1'b1;
            cnt_in = cnt_ff + 1'b1;
            total_in = total_ff + size_ff;
            rsp_valid_in = 1'b1;
            state_in = S_IDLE;
         end
         S_DROP_RD: begin
            raddr = j_ff[IDX_BITS-1:0];
            if (j_ff == cnt_ff) begin
               cnt_in = cnt_ff - 1'b1;
               rsp_valid_in = 1'b1;
               state_in = S_IDLE;
            end else begin
               state_in = S_DROP_WR;
            end
         end
         S_DROP_WR: begin
            we = 1'b1;
            waddr = IDX_BITS'(j_ff - 1'b1);
            wdata = rdata;
            j_in = j_ff + 1'b1;
            state_in = S_DROP_RD;
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
      rsp_total_in = total_in;
      rsp_cnt_in = cnt_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         cnt_ff <= '0;
         total_ff <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         cnt_ff <= cnt_in;
         total_ff <= total_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      i_ff <= i_in;
      j_ff <= j_in;
      size_ff <= size_in;
      addr_ff <= addr_in;
      cur_start_ff <= cur_start_in;
      cur_len_ff <= cur_len_in;
      status_ff <= status_in;
      rsp_total_ff <= rsp_total_in;
      rsp_cnt_ff <= rsp_cnt_in;
   end

   assign busy = (state_ff != S_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_status = status_ff;
   assign rsp_total_free_bytes = rsp_total_ff;
   assign rsp_ranges_in_use = 7'(rsp_cnt_ff);

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      cnt_ff <= MAX_CNT)
      else $error("range count exceeds table depth");

   a_refusal_keeps_total: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && status_ff != frci_pkg::ST_OK |-> total_ff == $past(total_ff))
      else $error("refused item changed the free total");

   a_accept_progress: assert property (@(posedge clock) disable iff (reset)
      start && !busy |=> busy || rsp_valid_ff)
      else $error("accepted item neither started nor answered");

endmodule

@@ rtl/frci_ram.sv @@
module frci_ram #(
   parameter int unsigned WIDTH = 8,
   parameter int unsigned DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] waddr,
   input  logic [WIDTH-1:0]         wdata,
   input  logic [$clog2(DEPTH)-1:0] raddr,
   output logic [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
      rdata <= mem[raddr];
   end

endmodule

@@ test/tb_free_range_coalescing_insert_unit.sv @@
`timescale 1ns / 1ps

module tb_free_range_coalescing_insert_unit;

   localparam int unsigned NUM_RANGES = 64;
   localparam int unsigned LEN_BITS = frci_pkg::LEN_BITS;

   typedef struct {
      frci_pkg::status_type status;
      logic [31:0] total;
      logic [6:0]  count;
   } insert_result_type;

   class free_table_scoreboard;
      logic [31:0] starts[$];
      logic [LEN_BITS-1:0] lengths[$];
      logic [31:0] total;
      insert_result_type pending[$];
      int errors;

      function new();
         total = 0;
         errors = 0;
      endfunction

      function frci_pkg::status_type place(logic [31:0] addr, logic [31:0] size);
         logic [LEN_BITS-1:0] bend;
         logic [LEN_BITS-1:0] s;
         logic [LEN_BITS-1:0] e;
         bit has_next;
         bend = LEN_BITS'(addr) + LEN_BITS'(size);
         for (int i = 0; i < starts.size(); i++) begin
            s = LEN_BITS'(starts[i]);
            e = s + lengths[i];
            if (s > bend) begin
               if (starts.size() >= NUM_RANGES) return frci_pkg::ST_FULL;
               starts.insert(i, addr);
               lengths.insert(i, LEN_BITS'(size));
               return frci_pkg::ST_OK;
            end
            if (s == bend) begin
               starts[i] = addr;
               lengths[i] += LEN_BITS'(size);
               return frci_pkg::ST_OK;
            end
            if (LEN_BITS'(addr) < e) return frci_pkg::ST_OVERLAP;
            if (LEN_BITS'(addr) == e) begin
               has_next = (i + 1) < starts.size();
               if (has_next && LEN_BITS'(starts[i+1]) < bend) return frci_pkg::ST_OVERLAP;
               lengths[i] += LEN_BITS'(size);
               if (has_next && LEN_BITS'(starts[i+1]) == bend) begin
                  lengths[i] += lengths[i+1];
                  starts.delete(i + 1);
                  lengths.delete(i + 1);
               end
               return frci_pkg::ST_OK;
            end
         end
         if (starts.size() >= NUM_RANGES) return frci_pkg::ST_FULL;
         starts.push_back(addr);
         lengths.push_back(LEN_BITS'(size));
         return frci_pkg::ST_OK;
      endfunction

      function void note_item(logic [31:0] addr, logic [31:0] raw);
         insert_result_type r;
         logic [31:0] size;
         if (raw == 0 || raw[31]) begin
            r.status = frci_pkg::ST_BAD_SIZE;
         end else begin
            size = raw < frci_pkg::MIN_BLOCK ? frci_pkg::MIN_BLOCK : raw;
            size = (size + frci_pkg::ALIGN_MASK) & ~frci_pkg::ALIGN_MASK;
            r.status = place(addr, size);
            if (r.status == frci_pkg::ST_OK) total += size;
         end
         r.total = total;
         r.count = 7'(starts.size());
         pending.push_back(r);
      endfunction

      function void check_result(logic [1:0] st, logic [31:0] tot, logic [6:0] cnt);
         insert_result_type r;
         if (pending.size() == 0) begin
            $error("result with no item outstanding");
            errors++;
            return;
         end
         r = pending.pop_front();
         if (st !== r.status) begin
            $error("status expected %0d actual %0d", r.status, st);
            errors++;
         end
         if (tot !== r.total) begin
            $error("total_free_bytes expected %0h actual %0h", r.total, tot);
            errors++;
         end
         if (cnt !== r.count) begin
            $error("ranges_in_use expected %0d actual %0d", r.count, cnt);
            errors++;
         end
      endfunction
   endclass

   logic clock;
   logic reset;
   logic start;
   logic busy;
   logic [31:0] req_block_address;
   logic signed [31:0] req_block_size;
   logic rsp_valid;
   logic [1:0] rsp_status;
   logic [31:0] rsp_total_free_bytes;
   logic [6:0] rsp_ranges_in_use;

   free_table_scoreboard board;
   logic [31:0] next_addr;

   free_range_coalescing_insert_unit DUT (
      .clock(clock),
      .reset(reset),
      .start(start),
      .busy(busy),
      .req_block_address(req_block_address),
      .req_block_size(req_block_size),
      .rsp_valid(rsp_valid),
      .rsp_status(rsp_status),
      .rsp_total_free_bytes(rsp_total_free_bytes),
      .rsp_ranges_in_use(rsp_ranges_in_use)
   );

   initial begin
      clock = 0;
      forever #4 clock = ~clock;
   end

   initial begin
      #40_000_000;
      $display("*** FAILED ***");
      $finish;
   end

   always @(posedge clock) begin
      if (!reset && rsp_valid) board.check_result(rsp_status, rsp_total_free_bytes,
                                                  rsp_ranges_in_use);
   end

   task automatic idle_gap();
      int n;
      n = ($urandom_range(0, 9) == 0) ? $urandom_range(5, 40) : $urandom_range(0, 2);
      if ($urandom_range(0, 3) == 0) n = 0;
      if (n > 0) start <= 1'b0;
      repeat (n) @(posedge clock);
   endtask

   task automatic send_item(logic [31:0] addr, logic [31:0] size);
      req_block_address <= addr;
      req_block_size <= size;
      start <= 1'b1;
      do @(posedge clock); while (busy);
      board.note_item(addr, size);
      idle_gap();
   endtask

   task automatic send_random();
      logic [31:0] addr;
      logic [31:0] size;
      int kind;
      kind = $urandom_range(0, 99);
      size = $urandom_range(1, 40);
      if ($urandom_range(0, 9) == 0) size = $urandom;
      if (kind < 8) begin
         size = ($urandom_range(0, 1) == 0) ? 32'd0 : ($urandom | 32'h8000_0000);
         addr = $urandom;
      end else if (kind < 40 && board.starts.size() > 0) begin
         int i;
         i = $urandom_range(0, board.starts.size() - 1);
         if ($urandom_range(0, 1) == 0)
            addr = board.starts[i] + 32'(board.lengths[i]);
         else
            addr = board.starts[i] - (((size < 8 ? 32'd8 : size) + 3) & ~32'd3);
      end else if (kind < 55 && board.starts.size() > 0) begin
         int i;
         i = $urandom_range(0, board.starts.size() - 1);
         addr = board.starts[i] + $urandom_range(0, 7);
      end else if (kind < 60) begin
         addr = $urandom;
      end else begin
         next_addr = next_addr + 32'($urandom_range(1, 16)) * 64;
         addr = next_addr;
      end
      send_item(addr, size);
   endtask

   initial begin
      board = new();
      next_addr = 32'h0010_0000;
      reset = 1'b1;
      start = 1'b0;
      req_block_address = 0;
      req_block_size = 0;
      repeat (4) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      send_item(32'h0000_1000, 32'd0);
      send_item(32'hFFFF_FFFF, 32'h8000_0000);
      send_item(32'h0000_0000, 32'hFFFF_FFFF);
      send_item(32'h0000_1000, 32'd1);
      send_item(32'h0000_1010, 32'd5);
      send_item(32'h0000_1008, 32'd8);
      send_item(32'h0000_1004, 32'd4);
      send_item(32'h0000_0FF8, 32'd7);
      send_item(32'h0000_2000, 32'd9);
      send_item(32'h0000_2020, 32'd16);
      send_item(32'h0000_200C, 32'd32);
      send_item(32'h0000_2010, 32'd16);
      send_item(32'h0000_200C, 32'd4);
      send_item(32'h0000_0000, 32'd8);
      send_item(32'hFFFF_FFF8, 32'h7FFF_FFFF);
      send_item(32'hFFFF_FFFC, 32'd4);
      send_item(32'h0000_0000, 32'h7FFF_FFFF);
      send_item(32'h8000_0000, 32'd3);
      for (int i = 0; i < 70; i++) send_item(32'h4000_0000 + 32'(i) * 64, 32'd8);
      send_item(32'h4000_0008, 32'd8);
      send_item(32'h4000_0010, 32'd48);

      repeat (560) send_random();
      start <= 1'b0;

      while (board.pending.size() > 0) @(posedge clock);
      repeat (300) @(posedge clock);
      if (board.errors == 0 && board.pending.size() == 0) begin
         $display("*** PASSED ***");
      end else begin
         $display("*** FAILED ***");
      end
      $finish;
   end
endmodule

@@ sim.f @@
rtl/frci_pkg.sv
rtl/frci_ram.sv
rtl/free_range_coalescing_insert_unit.sv
test/tb_free_range_coalescing_insert_unit.sv
